// File: sv/acwt_pkg.sv
// Shared types and codes for the ARP change watch table.
// Used by the top-level unit and the testbench; depends on nothing else.
`default_nettype none

package acwt_pkg;

    // Neighbor row types at or above this value are processed
    localparam logic [2:0] ROW_TYPE_MIN = 3'd3;

    // Result status codes
    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_UNWATCHED = 3'd1;
    localparam logic [2:0] ST_UNCHANGED = 3'd2;
    localparam logic [2:0] ST_NEW       = 3'd3;
    localparam logic [2:0] ST_CHANGED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // Zone mappings and configuration register layout
    localparam int ZONE_PAIRS = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Value of an unwatched zone
    localparam logic [31:0] ZONE_NONE = 32'd0;

    // One neighbor row request
    typedef struct packed {
        logic [2:0]  row_type;
        logic [31:0] iface_index;
        logic [31:0] ip_address;
        logic [3:0]  hw_len;
        logic [63:0] hw_addr;
        logic [31:0] now_time;
    } row_t;

    // One result
    typedef struct packed {
        logic [2:0] status;
        logic       changed;
        logic [5:0] entry_slot;
        logic [5:0] old_slot;
    } result_t;

endpackage

`default_nettype wire

// File: sv/acwt_entry_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
// Generic; no package dependency.
`default_nettype none

module acwt_entry_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/arp_change_watch_table_unit.sv
// ARP change watch table, top level.
// Depends on acwt_pkg and acwt_entry_ram.
//
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index (0..7:
//   iface_a, zone_a, iface_b, zone_b, ... iface_d, zone_d). Write only when
//   busy is low.
//   Requests: a row on "row" is taken at the clock edge where start is high
//   and busy is low. busy stays high while the row is worked on.
//   Results: "result" is valid for the single cycle where done is high. The
//   receiver cannot stall. busy is low in the done cycle, so the next
//   request may be taken in that same cycle.
//   Timing: ignored and unwatched rows finish after the zone lookup. A
//   watched row then scans the stored entries until one matches or the last
//   is passed, and goes through the append state when it appends or finds the table full.
//   The scan rate is set by the one read port of the entry memory, which
//   delivers one stored entry per cycle to the compare logic.
//   Reset: asynchronous, clears the configuration, the fill count and the
//   sequencer. Entries at or above the fill count are never read, so the memory
//   needs no clearing pass.
`default_nettype none

module arp_change_watch_table_unit
    import acwt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int HW_BYTES = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   start,
    input  wire row_t                   row,
    output logic                        busy,
    output logic                        done,
    output result_t                     result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW_W = 8 * HW_BYTES;

    // Entry word layout
    localparam int E_DT_LO  = 0;
    localparam int E_CR_LO  = E_DT_LO + 32;
    localparam int E_HW_LO  = E_CR_LO + 32;
    localparam int E_IP_LO  = E_HW_LO + HW_W;
    localparam int E_ZN_LO  = E_IP_LO + 32;
    localparam int E_LEN_LO = E_ZN_LO + 32;
    localparam int E_DEL    = E_LEN_LO + 4;
    localparam int E_W      = E_DEL + 1;

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ZONE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_APPEND = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [31:0]     iface_reg [ZONE_PAIRS];
    logic [31:0]     zmap_reg [ZONE_PAIRS];
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   cmp_addr_reg, cmp_addr_next;
    logic [AW-1:0]   old_addr_reg, old_addr_next;
    logic            mismatch_reg, mismatch_next;
    logic            done_reg, done_next;
    result_t         result_reg, result_next;

    // Captured row
    logic [2:0]      type_reg;
    logic [31:0]     rif_reg;
    logic [31:0]     ip_reg;
    logic [3:0]      len_reg;
    logic [HW_W-1:0] hw_reg;
    logic [31:0]     now_reg;
    logic [31:0]     zone_reg, zone_next;

    logic [3:0]      len_clamp;
    logic [63:0]     hw_masked;
    logic            accept;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [E_W-1:0]  ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [E_W-1:0]  ram_rdata;

    logic            hit;
    logic            same_hw;
    logic            last_entry;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Clamp length and drop bytes beyond it
    always_comb
    begin
        len_clamp = (row.hw_len > 4'(HW_BYTES)) ? 4'(HW_BYTES) : row.hw_len;
        for (int b = 0; b < 8; b++)
        begin
            hw_masked[b*8 +: 8] = (4'(b) < len_clamp) ? row.hw_addr[b*8 +: 8] : 8'd0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ZONE_PAIRS; k++)
            begin
                iface_reg[k] <= '0;
                zmap_reg[k]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[0])
            begin
                zmap_reg[cfg_index[2:1]] <= cfg_data;
            end
            else
            begin
                iface_reg[cfg_index[2:1]] <= cfg_data;
            end
        end
    end

    // Capture the request row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= row.row_type;
            rif_reg  <= row.iface_index;
            ip_reg   <= row.ip_address;
            len_reg  <= len_clamp;
            hw_reg   <= hw_masked[HW_W-1:0];
            now_reg  <= row.now_time;
        end
    end

    // Compare the entry coming out of the memory
    always_comb
    begin
        hit = !ram_rdata[E_DEL]
              && (ram_rdata[E_ZN_LO +: 32] == zone_reg)
              && (ram_rdata[E_IP_LO +: 32] == ip_reg);
        same_hw = (ram_rdata[E_LEN_LO +: 4] == len_reg)
                  && (ram_rdata[E_HW_LO +: HW_W] == hw_reg);
        last_entry = ((CW'(cmp_addr_reg) + CW'(1)) == count_reg);
    end

    // Sequencer: zone lookup, scan, write-back and append
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmp_addr_next = cmp_addr_reg;
        old_addr_next = old_addr_reg;
        mismatch_next = mismatch_reg;
        zone_next     = zone_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = cmp_addr_reg;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mismatch_next = 1'b0;
                    old_addr_next = '0;
                    state_next    = S_ZONE;
                end
            end

            S_ZONE:
            begin
                priority if (iface_reg[0] == rif_reg) zone_next = zmap_reg[0];
                else if (iface_reg[1] == rif_reg)     zone_next = zmap_reg[1];
                else if (iface_reg[2] == rif_reg)     zone_next = zmap_reg[2];
                else if (iface_reg[3] == rif_reg)     zone_next = zmap_reg[3];
                else                                  zone_next = ZONE_NONE;

                if (type_reg < ROW_TYPE_MIN)
                begin
                    result_next = '{ST_IGNORED, 1'b0, 6'd0, 6'd0};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (zone_next == ZONE_NONE)
                begin
                    result_next = '{ST_UNWATCHED, 1'b0, 6'd0, 6'd0};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    // Fetch the first entry
                    ram_re        = 1'b1;
                    ram_raddr     = '0;
                    cmp_addr_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit && same_hw)
                begin
                    result_next = '{ST_UNCHANGED, 1'b0, 6'(cmp_addr_reg), 6'd0};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (hit)
                begin
                    // Stamp the stale entry deleted and go append
                    ram_we    = 1'b1;
                    ram_waddr = cmp_addr_reg;
                    ram_wdata = ram_rdata;
                    ram_wdata[E_DEL] = 1'b1;
                    ram_wdata[E_DT_LO +: 32] = now_reg;
                    mismatch_next = 1'b1;
                    old_addr_next = cmp_addr_reg;
                    state_next    = S_APPEND;
                end
                else if (last_entry)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = cmp_addr_reg + AW'(1);
                    cmp_addr_next = cmp_addr_reg + AW'(1);
                end
            end

            S_APPEND:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (count_reg >= CW'(TABLE_DEPTH))
                begin
                    result_next = '{ST_FULL, 1'b0, 6'd0,
                                    mismatch_reg ? 6'(old_addr_reg) : 6'd0};
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[AW-1:0];
                    ram_wdata  = {1'b0, len_reg, zone_reg, ip_reg, hw_reg, now_reg, 32'd0};
                    count_next = count_reg + CW'(1);
                    result_next = '{mismatch_reg ? ST_CHANGED : ST_NEW, 1'b1,
                                    6'(count_reg),
                                    mismatch_reg ? 6'(old_addr_reg) : 6'd0};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            mismatch_reg <= mismatch_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= cmp_addr_next;
        old_addr_reg <= old_addr_next;
        zone_reg     <= zone_next;
        result_reg   <= result_next;
    end

    // Entry memory; the scan reads only below the fill count and the append
    // writes at it, in later cycles, so accesses never overlap
    acwt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (E_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Checks
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in work");

    a_changed_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.changed) |-> (result.status == ST_NEW || result.status == ST_CHANGED))
        else $error("append flagged with wrong status");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (done && result.changed))
        else $error("fill count moved without an append");

endmodule

`default_nettype wire

// File: test/arp_change_watch_table_unit_tb.sv
// Self-checking testbench for the ARP change watch table unit.
// Depends on acwt_pkg and arp_change_watch_table_unit; drives rows and zone
// registers, predicts each result and compares it with what the block returns.

module arp_change_watch_table_unit_tb
    import acwt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int MAC_BYTES = 8;
    localparam int SEGMENTS = 6;
    localparam int SEG_ROWS = 80;
    localparam int DIR_RESET_ROWS = 3;
    localparam int QUIET_LIMIT = 5000;
    localparam int POOL = 16;

    // Zone registers come in (interface, zone) pairs starting here
    localparam logic [CFG_INDEX_W-1:0] REG_IFACE_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_A  = 3'd1;

    typedef struct {
        row_t    r;
        result_t want;
    } dir_case_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    row_t                   row;
    logic                   busy;
    logic                   done;
    result_t                result;

    // Predictor copy of the zone map and the watch table
    logic [31:0] map_iface [ZONE_PAIRS] = '{default: '0};
    logic [31:0] map_zone  [ZONE_PAIRS] = '{default: '0};
    logic        slot_gone [DEPTH];
    logic [31:0] slot_ip   [DEPTH];
    logic [31:0] slot_zone [DEPTH];
    logic [3:0]  slot_len  [DEPTH];
    logic [63:0] slot_mac  [DEPTH];
    int          fill_count = 0;

    result_t     pending_results [$];
    dir_case_t   dir_cases [$];
    logic [31:0] next_iface [ZONE_PAIRS];
    logic [31:0] next_zone  [ZONE_PAIRS];
    int          status_seen [8] = '{default: 0};
    int          errors = 0;
    int          rows_sent = 0;
    int          quiet_cycles = 0;
    int          sender_idle_pct = 17;

    arp_change_watch_table_unit #(
        .TABLE_DEPTH(DEPTH),
        .HW_BYTES(MAC_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .row(row),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #5 clk = ~clk;

    // Keep only the valid hardware address bytes
    function automatic logic [63:0] byte_keep(input logic [3:0] len);
        if (len >= MAC_BYTES)
            return '1;
        return (64'd1 << (len * 8)) - 64'd1;
    endfunction

    // Work out the result of one row and update the predicted table
    function automatic result_t classify_row(input row_t r);
        result_t     res;
        logic [31:0] zone;
        logic [3:0]  len;
        logic [63:0] mac;
        int          hit;
        bit          stale;
        res = '0;
        if (r.row_type < ROW_TYPE_MIN)
            return res;
        // first matching pair wins, so scan from the last pair down
        zone = ZONE_NONE;
        for (int k = ZONE_PAIRS - 1; k >= 0; k--)
        begin
            if (map_iface[k] == r.iface_index)
                zone = map_zone[k];
        end
        if (zone == ZONE_NONE)
        begin
            res.status = ST_UNWATCHED;
            return res;
        end
        len = (r.hw_len > MAC_BYTES) ? 4'(MAC_BYTES) : r.hw_len;
        mac = r.hw_addr & byte_keep(len);
        hit = -1;
        stale = 1'b0;
        for (int y = 0; y < fill_count; y++)
        begin
            if (hit < 0 && !slot_gone[y] && slot_zone[y] == zone &&
                slot_ip[y] == r.ip_address)
                hit = y;
        end
        // a live entry with other hardware bytes is retired
        if (hit >= 0 && (slot_len[hit] != len || slot_mac[hit] != mac))
        begin
            stale = 1'b1;
            slot_gone[hit] = 1'b1;
        end
        if (hit >= 0 && !stale)
        begin
            res.status = ST_UNCHANGED;
            res.entry_slot = 6'(hit);
        end
        else
        begin
            if (stale)
                res.old_slot = 6'(hit);
            if (fill_count >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                slot_gone[fill_count] = 1'b0;
                slot_ip[fill_count] = r.ip_address;
                slot_zone[fill_count] = zone;
                slot_len[fill_count] = len;
                slot_mac[fill_count] = mac;
                res.status = stale ? ST_CHANGED : ST_NEW;
                res.changed = 1'b1;
                res.entry_slot = 6'(fill_count);
                fill_count++;
            end
        end
        return res;
    endfunction

    function automatic row_t mk_row(input logic [2:0] t, input logic [31:0] ifc,
                                    input logic [31:0] ip, input logic [3:0] len,
                                    input logic [63:0] hw, input logic [31:0] now);
        row_t r;
        r.row_type = t;
        r.iface_index = ifc;
        r.ip_address = ip;
        r.hw_len = len;
        r.hw_addr = hw;
        r.now_time = now;
        return r;
    endfunction

    task automatic add_case(input row_t r, input result_t want);
        dir_case_t c;
        c.r = r;
        c.want = want;
        dir_cases = {dir_cases, c};
    endtask

    // Issue one request after a random gap; return at the accepting edge
    task automatic send_row(input row_t r, input bit typed, input result_t want);
        result_t predicted;
        int      gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        row <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predicted = classify_row(r);
        pending_results = {pending_results, (typed ? want : predicted)};
        rows_sent++;
    endtask

    // Drop start and hold until every result is back and the block settles
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx[0])
            map_zone[idx >> 1] = val;
        else
            map_iface[idx >> 1] = val;
        @(posedge clk);
    endtask

    // Write all eight zone registers from next_iface / next_zone
    task automatic apply_zones();
        for (int k = 0; k < ZONE_PAIRS; k++)
        begin
            write_reg(REG_IFACE_A + 3'(2 * k), next_iface[k]);
            write_reg(REG_ZONE_A + 3'(2 * k), next_zone[k]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Compare each result with the oldest pending expectation
    always @(posedge clk)
    begin : catch_result
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d slot %0d", $time,
                         result.status, result.entry_slot);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("changed", 32'(want.changed), 32'(result.changed));
                check_field("entry_slot", 32'(want.entry_slot), 32'(result.entry_slot));
                check_field("old_slot", 32'(want.old_slot), 32'(result.old_slot));
                status_seen[result.status]++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] ip_pool  [POOL];
        logic [63:0] mac_last [POOL];
        logic [3:0]  len_last [POOL];
        logic [63:0] keep;
        row_t        r;
        int          p;
        int          counted;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        start <= 1'b0;
        row <= '0;

        // Directed rows; the first few run with the zone map still at reset
        add_case(mk_row(3'd0, 32'h0, 32'h0, 4'd0, 64'h0, 32'h0), result_t'{ST_IGNORED, 1'b0, 6'd0, 6'd0});
        add_case(mk_row(3'd2, '1, '1, 4'd15, '1, '1), result_t'{ST_IGNORED, 1'b0, 6'd0, 6'd0});
        add_case(mk_row(3'd3, 32'h0, 32'h1, 4'd6, 64'h1, 32'h1), result_t'{ST_UNWATCHED, 1'b0, 6'd0, 6'd0});
        // pair d maps interface 0 to zone 0, interface 0x12345 matches no pair
        add_case(mk_row(3'd3, 32'h0, 32'h1, 4'd6, 64'h1, 32'h2), result_t'{ST_UNWATCHED, 1'b0, 6'd0, 6'd0});
        add_case(mk_row(3'd4, 32'h12345, 32'h1, 4'd6, 64'h1, 32'h3), result_t'{ST_UNWATCHED, 1'b0, 6'd0, 6'd0});
        // new address, then same low bytes with noise above the length
        add_case(mk_row(3'd3, 32'h1, 32'h0A00_0001, 4'd6, 64'hFFFF_0011_2233_4455, 32'h0),
                 result_t'{ST_NEW, 1'b1, 6'd0, 6'd0});
        add_case(mk_row(3'd3, 32'h1, 32'h0A00_0001, 4'd6, 64'h1234_0011_2233_4455, 32'h10),
                 result_t'{ST_UNCHANGED, 1'b0, 6'd0, 6'd0});
        // high row type, one byte differs
        add_case(mk_row(3'd7, 32'h1, 32'h0A00_0001, 4'd6, 64'h0000_0011_2233_4456, 32'h20),
                 result_t'{ST_CHANGED, 1'b1, 6'd1, 6'd0});
        add_case(mk_row(3'd4, '1, '1, 4'd8, '1, '1), result_t'{ST_NEW, 1'b1, 6'd2, 6'd0});
        // length above eight is clamped
        add_case(mk_row(3'd4, '1, '1, 4'd15, '1, 32'h5), result_t'{ST_UNCHANGED, 1'b0, 6'd2, 6'd0});
        add_case(mk_row(3'd3, 32'h1, 32'h0A00_0001, 4'd0, 64'h0, 32'h30),
                 result_t'{ST_CHANGED, 1'b1, 6'd3, 6'd1});
        add_case(mk_row(3'd3, 32'h1, 32'h0A00_0001, 4'd0, 64'hDEAD_BEEF_0BAD_F00D, 32'h31),
                 result_t'{ST_UNCHANGED, 1'b0, 6'd3, 6'd0});
        // same address in two zones; pair c repeats interface 1 and must lose to pair a
        add_case(mk_row(3'd6, '1, 32'h0, 4'd8, 64'h0, 32'h0), result_t'{ST_NEW, 1'b1, 6'd4, 6'd0});
        add_case(mk_row(3'd3, 32'h1, 32'h0, 4'd8, 64'h0, 32'h40), result_t'{ST_NEW, 1'b1, 6'd5, 6'd0});
        add_case(mk_row(3'd5, 32'h1, 32'h0, 4'd8, 64'h0, 32'h41), result_t'{ST_UNCHANGED, 1'b0, 6'd5, 6'd0});
        add_case(mk_row(3'd6, '1, 32'h0, 4'd9, 64'h0, 32'h42), result_t'{ST_UNCHANGED, 1'b0, 6'd4, 6'd0});
        add_case(mk_row(3'd1, 32'h1, 32'h0, 4'd8, 64'h0, 32'h43), result_t'{ST_IGNORED, 1'b0, 6'd0, 6'd0});

        for (int i = 0; i < POOL; i++)
        begin
            ip_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? '1 : $urandom;
            mac_last[i] = {$urandom, $urandom};
            len_last[i] = 4'($urandom_range(0, 15));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (dir_cases[i])
        begin
            if (i == DIR_RESET_ROWS)
            begin
                wait_idle();
                next_iface = '{32'h1, '1, 32'h1, 32'h0};
                next_zone  = '{32'h1, '1, '1, ZONE_NONE};
                apply_zones();
            end
            send_row(dir_cases[i].r, 1'b1, dir_cases[i].want);
        end

        // Random part: a new zone map per segment, idle rate by segment pair
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            sender_idle_pct = (seg < 2) ? 17 : (seg < 4) ? 60 : 0;
            wait_idle();
            for (int k = 0; k < ZONE_PAIRS; k++)
            begin
                case (seg)
                    0:
                    begin
                        next_iface[k] = 32'(k + 2);
                        next_zone[k] = 32'(k + 2);
                    end
                    1:
                    begin
                        next_iface[k] = (k == 0) ? 32'h0 : (k == 1) ? '1 : $urandom;
                        next_zone[k] = (k == 1) ? ZONE_NONE : (k == 2) ? $urandom : '1;
                    end
                    default:
                    begin
                        case ($urandom_range(4))
                            0: next_iface[k] = 32'h0;
                            1: next_iface[k] = 32'h1;
                            2: next_iface[k] = 32'h2;
                            3: next_iface[k] = '1;
                            default: next_iface[k] = $urandom;
                        endcase
                        case ($urandom_range(5))
                            0: next_zone[k] = ZONE_NONE;
                            1: next_zone[k] = 32'h1;
                            2: next_zone[k] = 32'h2;
                            3: next_zone[k] = '1;
                            default: next_zone[k] = 32'($urandom_range(1, 6));
                        endcase
                    end
                endcase
            end
            apply_zones();

            counted = 0;
            while (counted < SEG_ROWS)
            begin
                r.row_type = ($urandom_range(9) == 0) ? 3'($urandom_range(0, 2))
                                                       : 3'($urandom_range(3, 7));
                r.iface_index = ($urandom_range(99) < 85) ? map_iface[$urandom_range(3)]
                                                           : $urandom;
                p = $urandom_range(POOL - 1);
                r.ip_address = ip_pool[p];
                r.now_time = $urandom;
                if ($urandom_range(99) < 20)
                begin
                    // fresh hardware address for this neighbor
                    len_last[p] = 4'($urandom_range(0, 15));
                    mac_last[p] = {$urandom, $urandom};
                    r.hw_len = len_last[p];
                    r.hw_addr = mac_last[p];
                end
                else
                begin
                    // same valid bytes, random noise beyond the length
                    r.hw_len = (len_last[p] >= MAC_BYTES) ? 4'($urandom_range(8, 15))
                                                          : len_last[p];
                    keep = byte_keep(r.hw_len);
                    r.hw_addr = (mac_last[p] & keep) | ({$urandom, $urandom} & ~keep);
                end
                send_row(r, 1'b0, '0);
                if (r.row_type >= ROW_TYPE_MIN)
                    counted++;
            end
        end

        wait_idle();
        repeat (DEPTH + 4) @(posedge clk);

        $display("Ran %0d rows over %0d zone maps, table filled to %0d slots", rows_sent,
                 SEGMENTS + 2, fill_count);
        $display("Results: %0d ignored, %0d unwatched, %0d unchanged, %0d new, %0d changed, %0d full",
                 status_seen[ST_IGNORED], status_seen[ST_UNWATCHED], status_seen[ST_UNCHANGED],
                 status_seen[ST_NEW], status_seen[ST_CHANGED], status_seen[ST_FULL]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
sv/acwt_pkg.sv
sv/acwt_entry_ram.sv
sv/arp_change_watch_table_unit.sv
test/arp_change_watch_table_unit_tb.sv
